// File: rtl/smae_pkg.sv
// ----------------------------------------------------------------------------
// smae_pkg
// types, constants and codes shared by the small matrix arithmetic engine
// ----------------------------------------------------------------------------
package smae_pkg;

  localparam int DEF_MAX_DIM   = 8;
  localparam int DEF_ELEM_BITS = 16;

  localparam int OP_W       = 3;
  localparam int IDX_W      = 3;
  localparam int IN_ELEM_W  = 16;
  localparam int DIM_W      = 4;
  localparam int SCALE_W    = 16;
  localparam int FRAC_BITS  = 8;
  localparam int RES_W      = 41;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIM_W-1:0]          DIM_RESET   = DIM_W'(1);
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 3'd0,
    OP_LOAD_B  = 3'd1,
    OP_SUM     = 3'd2,
    OP_DIFF    = 3'd3,
    OP_PRODUCT = 3'd4,
    OP_SCALE_A = 3'd5,
    OP_SCALE_B = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHAPE = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 3'd0,
    CFG_A_COLS = 3'd1,
    CFG_B_ROWS = 3'd2,
    CFG_B_COLS = 3'd3,
    CFG_SCALE  = 3'd4
  } cfg_reg_t;

  // what the dispatch step does with the captured request
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LOAD,
    KIND_SINGLE,
    KIND_MAC
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ISSUE,
    S_WAIT1,
    S_WAIT2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]             opcode;
    logic [IDX_W-1:0]            row_index;
    logic [IDX_W-1:0]            col_index;
    logic signed [IN_ELEM_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic [STATUS_W-1:0]     status;
  } out_item_t;

  typedef struct packed {
    logic             capture;
    logic             write;
    logic             issue;
    logic             clear_acc;
    logic             load_out;
    logic [DIM_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [DIM_W-1:0] terms;
  } stat_t;

endpackage

// File: rtl/smae_ram.sv
// ----------------------------------------------------------------------------
// smae_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module smae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/smae_ctrl.sv
// ----------------------------------------------------------------------------
// smae_ctrl
// sequencer: request intake, multiply-accumulate term count, result handoff
// ----------------------------------------------------------------------------
module smae_ctrl import smae_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t           state, state_next;
  logic [DIM_W-1:0] k, k_next;
  logic             out_valid_next;
  logic [DIM_W-1:0] last_k;

  assign last_k = stat.terms - DIM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    k_next         = k;
    out_valid_next = out_valid;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.k          = k;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        k_next   = '0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.clear_acc = 1'b1;
        unique case (stat.kind)
          KIND_LOAD: begin
            cmd.write  = 1'b1;
            state_next = S_DONE;
          end
          KIND_SINGLE: begin
            cmd.issue  = 1'b1;
            state_next = S_WAIT1;
          end
          KIND_MAC: begin
            cmd.issue  = 1'b1;
            k_next     = k + DIM_W'(1);
            state_next = (k == last_k) ? S_WAIT1 : S_ISSUE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_ISSUE: begin
        cmd.issue  = 1'b1;
        k_next     = k + DIM_W'(1);
        state_next = (k == last_k) ? S_WAIT1 : S_ISSUE;
      end
      S_WAIT1: begin
        state_next = S_WAIT2;
      end
      S_WAIT2: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // read addresses stay inside the term count
  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (k < stat.terms))
    else $error("read issued past the last term");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.load_out)
    else $error("output register overwritten while stalled");

  // a loaded result is offered in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

// File: rtl/smae_dp.sv
// ----------------------------------------------------------------------------
// smae_dp
// datapath: config registers, element stores, shape checks, shared multiplier
// ----------------------------------------------------------------------------
module smae_dp import smae_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output out_item_t             out_data
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int MUL_B_W = (ELEM_BITS > SCALE_W) ? ELEM_BITS : SCALE_W;
  localparam int TERM_W  = ELEM_BITS + MUL_B_W;
  localparam int EXT_W   = (TERM_W > RES_W) ? TERM_W : RES_W;
  localparam int EV_W    = (ELEM_BITS > IN_ELEM_W) ? ELEM_BITS : IN_ELEM_W;
  localparam logic [DIM_W:0] MAXD = (DIM_W + 1)'(MAX_DIM);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] r,
                                               input logic [DIM_W-1:0] c);
    return ADDR_W'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return ({1'b0, v} > MAXD) ? MAXD[DIM_W-1:0] : v;
  endfunction

  // configuration
  logic [DIM_W-1:0]          a_rows, a_cols, b_rows, b_cols;
  logic signed [SCALE_W-1:0] scale_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows       <= DIM_RESET;
      a_cols       <= DIM_RESET;
      b_rows       <= DIM_RESET;
      b_cols       <= DIM_RESET;
      scale_factor <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_A_ROWS: a_rows       <= cfg_data[DIM_W-1:0];
        CFG_A_COLS: a_cols       <= cfg_data[DIM_W-1:0];
        CFG_B_ROWS: b_rows       <= cfg_data[DIM_W-1:0];
        CFG_B_COLS: b_cols       <= cfg_data[DIM_W-1:0];
        CFG_SCALE:  scale_factor <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] ar, ac, br, bc;
  assign ar = sat_dim(a_rows);
  assign ac = sat_dim(a_cols);
  assign br = sat_dim(b_rows);
  assign bc = sat_dim(b_cols);

  // captured request
  op_t                         op_q;
  logic [DIM_W-1:0]            row_q, col_q;
  logic [ELEM_BITS-1:0]        elem_q;
  logic signed [EV_W-1:0]      ev_ext;

  assign ev_ext = EV_W'(in_data.element_value);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(in_data.opcode);
      row_q  <= {1'b0, in_data.row_index};
      col_q  <= {1'b0, in_data.col_index};
      elem_q <= ev_ext[ELEM_BITS-1:0];
    end
  end

  // shape and range checks
  logic    in_a, in_b, in_p;
  status_t code;

  assign in_a = (row_q < ar) && (col_q < ac);
  assign in_b = (row_q < br) && (col_q < bc);
  assign in_p = (row_q < ar) && (col_q < bc);

  always_comb begin
    code       = ST_OK;
    stat.kind  = KIND_NONE;
    stat.terms = DIM_W'(1);
    unique case (op_q) inside
      OP_LOAD_A: begin
        if (in_a) stat.kind = KIND_LOAD;
        else      code      = ST_RANGE;
      end
      OP_LOAD_B: begin
        if (in_b) stat.kind = KIND_LOAD;
        else      code      = ST_RANGE;
      end
      OP_SUM, OP_DIFF: begin
        if (ar != br || ac != bc) code      = ST_SHAPE;
        else if (!in_a)           code      = ST_RANGE;
        else                      stat.kind = KIND_SINGLE;
      end
      OP_PRODUCT: begin
        if (ac != br) begin
          code = ST_SHAPE;
        end else if (!in_p) begin
          code = ST_RANGE;
        end else if (ac != '0) begin
          stat.kind  = KIND_MAC;
          stat.terms = ac;
        end
      end
      OP_SCALE_A: begin
        if (in_a) stat.kind = KIND_SINGLE;
        else      code      = ST_RANGE;
      end
      OP_SCALE_B: begin
        if (in_b) stat.kind = KIND_SINGLE;
        else      code      = ST_RANGE;
      end
      default: ;
    endcase
  end

  // element stores
  logic [ADDR_W-1:0]           addr_rc, addr_a_rd, addr_b_rd;
  logic signed [ELEM_BITS-1:0] a_rd, b_rd;
  logic                        is_mac;

  assign is_mac    = (op_q == OP_PRODUCT);
  assign addr_rc   = addr_of(row_q, col_q);
  assign addr_a_rd = is_mac ? addr_of(row_q, cmd.k) : addr_rc;
  assign addr_b_rd = is_mac ? addr_of(cmd.k, col_q) : addr_rc;

  smae_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.write && op_q == OP_LOAD_A),
    .waddr (addr_rc),
    .wdata (elem_q),
    .re    (cmd.issue),
    .raddr (addr_a_rd),
    .rdata (a_rd)
  );

  smae_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.write && op_q == OP_LOAD_B),
    .waddr (addr_rc),
    .wdata (elem_q),
    .re    (cmd.issue),
    .raddr (addr_b_rd),
    .rdata (b_rd)
  );

  // pipeline valids
  logic rd_v, mul_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= cmd.issue;
      mul_v <= rd_v;
    end
  end

  // shared multiplier and adder stage
  logic signed [ELEM_BITS-1:0] mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [TERM_W-1:0]    prod, term;

  assign mul_a = (op_q == OP_SCALE_B) ? b_rd : a_rd;
  assign mul_b = is_mac ? MUL_B_W'(b_rd) : MUL_B_W'(scale_factor);
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rd_v) begin
      case (op_q)
        OP_SUM:  term <= TERM_W'(a_rd) + TERM_W'(b_rd);
        OP_DIFF: term <= TERM_W'(a_rd) - TERM_W'(b_rd);
        default: term <= prod;
      endcase
    end
  end

  // accumulate products, pass other terms, or drop the fraction toward zero for scaled reads
  logic signed [TERM_W-1:0] rnd, shifted;
  logic signed [EXT_W-1:0]  term_ext, shifted_ext;
  logic signed [RES_W-1:0]  acc;

  assign rnd         = term + {{(TERM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{term[TERM_W-1]}}};
  assign shifted     = rnd >>> FRAC_BITS;
  assign term_ext    = EXT_W'(term);
  assign shifted_ext = EXT_W'(shifted);

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc <= '0;
    end else if (mul_v) begin
      case (op_q) inside
        OP_PRODUCT:           acc <= acc + term_ext[RES_W-1:0];
        OP_SCALE_A, OP_SCALE_B: acc <= shifted_ext[RES_W-1:0];
        default:              acc <= term_ext[RES_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.result_value <= acc;
      out_data.status       <= code;
    end
  end

endmodule

// File: rtl/small_matrix_arith_engine_unit.sv
// ----------------------------------------------------------------------------
// small_matrix_arith_engine_unit
// two-matrix integer engine: load, sum, difference, product, scaled element
// ----------------------------------------------------------------------------
// Loads, requests that end in an error status, the unused opcode and a product
// over zero columns go from dispatch straight to the output register; sum,
// difference and scaled reads first pass the store read, term and accumulator
// registers; a product element sums one term per column of A in use (column
// count saturated at MAX_DIM), one multiply-add per cycle through the single
// shared multiplier fed by one read port on each element store. One request
// is in flight at a time; the next transfer is taken as soon as the previous
// result sits in the output register, even while that result is stalled.
// Reading an element that was never loaded returns an unspecified value.
module small_matrix_arith_engine_unit import smae_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  cmd_t  cmd;
  stat_t stat;

  smae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  smae_dp #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the small matrix arithmetic engine: loads, sums,
// differences, products and scaled reads are predicted in the bench from its
// own copy of both element stores and the shape registers, and every result
// transfer is compared field by field in order. Register settings change only
// between phases, after the engine has drained.
// ----------------------------------------------------------------------------
module testbench;
  import smae_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
  localparam int N_ELEM = DEF_MAX_DIM * DEF_MAX_DIM;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  small_matrix_arith_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shape and scale registers as last written
  logic [DIM_W-1:0]          reg_a_rows = DIM_RESET;
  logic [DIM_W-1:0]          reg_a_cols = DIM_RESET;
  logic [DIM_W-1:0]          reg_b_rows = DIM_RESET;
  logic [DIM_W-1:0]          reg_b_cols = DIM_RESET;
  logic signed [SCALE_W-1:0] reg_scale  = SCALE_RESET;

  logic signed [IN_ELEM_W-1:0] mat_a [N_ELEM];
  logic signed [IN_ELEM_W-1:0] mat_b [N_ELEM];
  bit a_loaded [N_ELEM];
  bit b_loaded [N_ELEM];

  in_item_t  request_queue [$];
  out_item_t result_queue [$];

  int queued_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int setting_count = 1;
  int op_seen [8];
  int status_seen [4];

  int send_pct = 0;
  int stall_pct = 0;
  int send_gap = 0;
  int stall_left = 0;

  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_cnt = 0;

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    return (d > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(d);
  endfunction

  function automatic logic signed [RES_W-1:0] scale_elem(logic signed [IN_ELEM_W-1:0] e);
    longint p;
    p = longint'(e) * longint'(reg_scale);
    p = p / (longint'(1) << FRAC_BITS);
    return RES_W'(p);
  endfunction

  // applies one request to the shadow stores and returns its result
  function automatic out_item_t matrix_result(in_item_t it);
    int ar, ac, br, bc, r, c, k;
    logic signed [RES_W-1:0] acc;
    status_t st;
    out_item_t o;
    ar = eff_dim(reg_a_rows);
    ac = eff_dim(reg_a_cols);
    br = eff_dim(reg_b_rows);
    bc = eff_dim(reg_b_cols);
    r = it.row_index;
    c = it.col_index;
    acc = '0;
    st = ST_OK;
    case (it.opcode) inside
      OP_LOAD_A: begin
        if (r < ar && c < ac) mat_a[r*DEF_MAX_DIM+c] = it.element_value;
        else st = ST_RANGE;
      end
      OP_LOAD_B: begin
        if (r < br && c < bc) mat_b[r*DEF_MAX_DIM+c] = it.element_value;
        else st = ST_RANGE;
      end
      OP_SUM, OP_DIFF: begin
        if (ar != br || ac != bc) st = ST_SHAPE;
        else if (r >= ar || c >= ac) st = ST_RANGE;
        else if (it.opcode == OP_SUM)
          acc = mat_a[r*DEF_MAX_DIM+c] + mat_b[r*DEF_MAX_DIM+c];
        else acc = mat_a[r*DEF_MAX_DIM+c] - mat_b[r*DEF_MAX_DIM+c];
      end
      OP_PRODUCT: begin
        if (ac != br) st = ST_SHAPE;
        else if (r >= ar || c >= bc) st = ST_RANGE;
        else
          for (k = 0; k < ac; k++)
            acc = acc + mat_a[r*DEF_MAX_DIM+k] * mat_b[k*DEF_MAX_DIM+c];
      end
      OP_SCALE_A: begin
        if (r >= ar || c >= ac) st = ST_RANGE;
        else acc = scale_elem(mat_a[r*DEF_MAX_DIM+c]);
      end
      OP_SCALE_B: begin
        if (r >= br || c >= bc) st = ST_RANGE;
        else acc = scale_elem(mat_b[r*DEF_MAX_DIM+c]);
      end
      default: ;
    endcase
    o.result_value = acc;
    o.status = st;
    return o;
  endfunction

  // queues a request unless it would read an element never loaded
  function automatic bit enqueue_request(in_item_t it);
    int ar, ac, br, bc, r, c, k;
    bit ok;
    ar = eff_dim(reg_a_rows);
    ac = eff_dim(reg_a_cols);
    br = eff_dim(reg_b_rows);
    bc = eff_dim(reg_b_cols);
    r = it.row_index;
    c = it.col_index;
    ok = 1'b1;
    case (it.opcode) inside
      OP_LOAD_A: if (r < ar && c < ac) a_loaded[r*DEF_MAX_DIM+c] = 1'b1;
      OP_LOAD_B: if (r < br && c < bc) b_loaded[r*DEF_MAX_DIM+c] = 1'b1;
      OP_SUM, OP_DIFF: begin
        if (ar == br && ac == bc && r < ar && c < ac)
          ok = a_loaded[r*DEF_MAX_DIM+c] && b_loaded[r*DEF_MAX_DIM+c];
      end
      OP_PRODUCT: begin
        if (ac == br && r < ar && c < bc)
          for (k = 0; k < ac; k++)
            ok = ok && a_loaded[r*DEF_MAX_DIM+k] && b_loaded[k*DEF_MAX_DIM+c];
      end
      OP_SCALE_A: if (r < ar && c < ac) ok = a_loaded[r*DEF_MAX_DIM+c];
      OP_SCALE_B: if (r < br && c < bc) ok = b_loaded[r*DEF_MAX_DIM+c];
      default: ;
    endcase
    if (ok) begin
      request_queue.push_back(it);
      queued_count++;
    end
    return ok;
  endfunction

  function automatic in_item_t mk_req(logic [OP_W-1:0] op, int r, int c,
                                      logic [IN_ELEM_W-1:0] v);
    in_item_t it;
    it.opcode = op;
    it.row_index = IDX_W'(r);
    it.col_index = IDX_W'(c);
    it.element_value = v;
    return it;
  endfunction

  function automatic logic [IN_ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return IN_ELEM_W'($urandom);
    endcase
  endfunction

  function automatic int random_dim();
    case ($urandom_range(0, 19)) inside
      0: return 0;
      1: return $urandom_range(9, 15);
      2, 3: return DEF_MAX_DIM;
      4, 5, 6, 7: return $urandom_range(5, 7);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    int pick, nr, nc;
    pick = $urandom_range(0, 99);
    if (pick < 14) it.opcode = OP_LOAD_A;
    else if (pick < 28) it.opcode = OP_LOAD_B;
    else if (pick < 40) it.opcode = OP_SUM;
    else if (pick < 52) it.opcode = OP_DIFF;
    else if (pick < 70) it.opcode = OP_PRODUCT;
    else if (pick < 80) it.opcode = OP_SCALE_A;
    else if (pick < 90) it.opcode = OP_SCALE_B;
    else if (pick < 94) it.opcode = OP_SPARE;
    else it.opcode = OP_W'($urandom);
    case (it.opcode) inside
      OP_LOAD_A, OP_SUM, OP_DIFF, OP_SCALE_A: begin
        nr = eff_dim(reg_a_rows);
        nc = eff_dim(reg_a_cols);
      end
      OP_LOAD_B, OP_SCALE_B: begin
        nr = eff_dim(reg_b_rows);
        nc = eff_dim(reg_b_cols);
      end
      OP_PRODUCT: begin
        nr = eff_dim(reg_a_rows);
        nc = eff_dim(reg_b_cols);
      end
      default: begin
        nr = DEF_MAX_DIM;
        nc = DEF_MAX_DIM;
      end
    endcase
    if (nr != 0 && nc != 0 && $urandom_range(0, 99) < 85) begin
      it.row_index = IDX_W'($urandom_range(0, nr - 1));
      it.col_index = IDX_W'($urandom_range(0, nc - 1));
    end else begin
      it.row_index = IDX_W'($urandom);
      it.col_index = IDX_W'($urandom);
    end
    it.element_value = pick_value();
    return it;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_A_ROWS: reg_a_rows = data[DIM_W-1:0];
      CFG_A_COLS: reg_a_cols = data[DIM_W-1:0];
      CFG_B_ROWS: reg_b_rows = data[DIM_W-1:0];
      CFG_B_COLS: reg_b_cols = data[DIM_W-1:0];
      CFG_SCALE:  reg_scale  = data;
      default: ;
    endcase
  endtask

  // dimension writes sometimes carry junk above the 4-bit field
  function automatic logic [CFG_DATA_W-1:0] dim_word(int d);
    logic [CFG_DATA_W-DIM_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? (CFG_DATA_W-DIM_W)'($urandom) : '0;
    return {junk, DIM_W'(d)};
  endfunction

  task automatic set_shape(int ar, int ac, int br, int bc, logic [CFG_DATA_W-1:0] sc);
    write_reg(CFG_A_ROWS, dim_word(ar));
    write_reg(CFG_A_COLS, dim_word(ac));
    write_reg(CFG_B_ROWS, dim_word(br));
    write_reg(CFG_B_COLS, dim_word(bc));
    write_reg(CFG_SCALE, sc);
    setting_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != queued_count || result_queue.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      result_queue.push_back(matrix_result(in_data));
      op_seen[in_data.opcode]++;
      accepted_count++;
    end
    if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (request_queue.size() != 0 && $urandom_range(0, 99) < send_pct) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(1, 19) - 1;
      end else if (request_queue.size() != 0) begin
        in_data <= request_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      checked_count++;
      status_seen[out_data.status]++;
      if (result_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t unexpected result transfer: value %0d status %0d",
                   $realtime, out_data.result_value, out_data.status);
      end else begin
        want = result_queue.pop_front();
        if (out_data.result_value !== want.result_value) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t result_value: expected %0d, got %0d", $realtime,
                     want.result_value, out_data.result_value);
        end
        if (out_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t status: expected %0d, got %0d", $realtime,
                     want.status, out_data.status);
        end
      end
    end
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 19) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    in_item_t it;
    int ph, ar, ac, br, bc, r, c, s;
    logic [CFG_DATA_W-1:0] sc;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset shape, unit scale
    send_pct = 10;
    stall_pct = 10;
    void'(enqueue_request(mk_req(OP_LOAD_A, 0, 0, 16'h7FFF)));
    void'(enqueue_request(mk_req(OP_LOAD_B, 0, 0, 16'h8000)));
    void'(enqueue_request(mk_req(OP_SUM, 0, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_DIFF, 0, 0, 16'hFFFF)));
    void'(enqueue_request(mk_req(OP_PRODUCT, 0, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_SCALE_A, 0, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_SCALE_B, 0, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_SPARE, 7, 7, 16'h1234)));
    void'(enqueue_request(mk_req(OP_LOAD_A, 0, 1, 16'h5555)));
    void'(enqueue_request(mk_req(OP_SCALE_B, 7, 7, 16'h0000)));

    // zero rows, saturated columns, most negative scale
    wait_drained();
    set_shape(0, 15, 8, 1, 16'h8000);
    void'(enqueue_request(mk_req(OP_LOAD_A, 0, 0, 16'h0001)));
    void'(enqueue_request(mk_req(OP_PRODUCT, 7, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_SUM, 7, 7, 16'h0000)));
    void'(enqueue_request(mk_req(OP_LOAD_B, 7, 0, 16'hFFFF)));
    void'(enqueue_request(mk_req(OP_SCALE_B, 7, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_SCALE_A, 0, 0, 16'h0000)));

    // non-square product, largest scale, truncation of a negative product
    wait_drained();
    set_shape(1, 2, 2, 1, 16'h7FFF);
    void'(enqueue_request(mk_req(OP_LOAD_A, 0, 0, 16'h8000)));
    void'(enqueue_request(mk_req(OP_LOAD_A, 0, 1, 16'h8000)));
    void'(enqueue_request(mk_req(OP_LOAD_B, 0, 0, 16'h8000)));
    void'(enqueue_request(mk_req(OP_LOAD_B, 1, 0, 16'hFFFF)));
    void'(enqueue_request(mk_req(OP_PRODUCT, 0, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_SCALE_B, 1, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_SUM, 0, 0, 16'h0000)));
    void'(enqueue_request(mk_req(OP_DIFF, 1, 1, 16'h0000)));

    ph = 0;
    while (queued_count < 1250) begin
      wait_drained();
      s = $urandom_range(0, 9);
      ar = random_dim();
      ac = random_dim();
      if (s < 4) begin
        br = ar;
        bc = ac;
      end else if (s < 8) begin
        br = ac;
        bc = random_dim();
      end else begin
        br = random_dim();
        bc = random_dim();
      end
      case ($urandom_range(0, 7))
        0: sc = 16'h8000;
        1: sc = 16'h7FFF;
        2: sc = 16'h0100;
        3: sc = 16'h0000;
        4: sc = 16'hFFFF;
        default: sc = CFG_DATA_W'($urandom);
      endcase
      set_shape(ar, ac, br, bc, sc);

      if (queued_count > 1050 || ph == 1) begin
        send_pct = 0;
        stall_pct = (ph == 1) ? 10 : 0;
      end else begin
        case ($urandom_range(0, 3))
          0: send_pct = 0;
          1: send_pct = 3;
          2: send_pct = 10;
          default: send_pct = 25;
        endcase
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 3;
          2: stall_pct = 10;
          default: stall_pct = 25;
        endcase
      end

      // fill both matrices so reads see loaded elements
      for (r = 0; r < eff_dim(reg_a_rows); r++)
        for (c = 0; c < eff_dim(reg_a_cols); c++)
          if (!a_loaded[r*DEF_MAX_DIM+c] || $urandom_range(0, 9) == 0)
            void'(enqueue_request(mk_req(OP_LOAD_A, r, c, pick_value())));
      for (r = 0; r < eff_dim(reg_b_rows); r++)
        for (c = 0; c < eff_dim(reg_b_cols); c++)
          if (!b_loaded[r*DEF_MAX_DIM+c] || $urandom_range(0, 9) == 0)
            void'(enqueue_request(mk_req(OP_LOAD_B, r, c, pick_value())));

      repeat (80) begin
        do it = random_request();
        while (!enqueue_request(it));
      end
      if (ph == 1) hold_req = ~hold_req;
      ph++;
    end

    wait_drained();
    repeat (20) @(negedge clk);

    $display("covered %0d requests over %0d register settings: %0d loads, %0d sum/diff,",
             accepted_count, setting_count, op_seen[OP_LOAD_A] + op_seen[OP_LOAD_B],
             op_seen[OP_SUM] + op_seen[OP_DIFF]);
    $display("  %0d products, %0d scaled reads, %0d spare opcodes; %0d results checked,",
             op_seen[OP_PRODUCT], op_seen[OP_SCALE_A] + op_seen[OP_SCALE_B],
             op_seen[OP_SPARE], checked_count);
    $display("  %0d shape and %0d range errors",
             status_seen[ST_SHAPE], status_seen[ST_RANGE]);
    if (mismatch_count == 0 && result_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", result_queue.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: small_matrix_arith_engine_unit.f
rtl/smae_pkg.sv
rtl/smae_ram.sv
rtl/smae_ctrl.sv
rtl/smae_dp.sv
rtl/small_matrix_arith_engine_unit.sv
tb/testbench.sv
